// ===== rtl/lrcc_pkg.sv =====
`default_nettype none

package lrcc_pkg;

   // Number of palette entries in the rainbow cycle.
   localparam logic [3:0] PALETTE_SIZE = 4'd7;

   // Configuration register indexes.
   localparam logic [2:0] REG_STEP_DELAY   = 3'd0;
   localparam logic [2:0] REG_BRIGHTNESS   = 3'd1;
   localparam logic [2:0] REG_INVERT_DUTY  = 3'd2;
   localparam logic [2:0] REG_PWM_MAX      = 3'd3;
   localparam logic [2:0] REG_HAS_WHITE    = 3'd4;

   // Serial arithmetic widths and constant divisors.
   localparam int          ACC_W     = 25;
   localparam int          REM_W     = 9;
   localparam logic [8:0]  DIV_PCT   = 9'd100;
   localparam logic [8:0]  DIV_FULL  = 9'd255;

   // Iteration counts, minus one, for each serial pass.
   localparam logic [4:0]  MUL1_LAST = 5'd7;   // 8 bits of the channel value
   localparam logic [4:0]  DIV1_LAST = 5'd14;  // 15-bit product divided by 100
   localparam logic [4:0]  MUL2_LAST = 5'd8;   // 9-bit scaled channel
   localparam logic [4:0]  DIV2_LAST = 5'd24;  // 25-bit product divided by 255

   typedef logic [7:0]       chan_type;
   typedef chan_type [2:0]   rgb_type;   // index 0 red, 1 green, 2 blue

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LOAD,
      ST_MUL1,
      ST_DIV1,
      ST_MUL2,
      ST_DIV2,
      ST_STORE,
      ST_OUT
   } lrcc_state_type;

   // Rainbow target for a palette index; index zero targets cyan like index one.
   function automatic rgb_type palette_target(input logic [2:0] idx);
      rgb_type t;
      case (idx)
         3'd7:    t = '{8'd0,   8'd0,   8'd255};   // red
         3'd6:    t = '{8'd0,   8'd255, 8'd0};     // green
         3'd5:    t = '{8'd255, 8'd0,   8'd0};     // blue
         3'd4:    t = '{8'd0,   8'd255, 8'd255};   // yellow
         3'd3:    t = '{8'd255, 8'd0,   8'd255};   // magenta
         3'd2:    t = '{8'd80,  8'd0,   8'd80};    // purple
         default: t = '{8'd255, 8'd255, 8'd0};     // cyan
      endcase
      return t;
   endfunction

endpackage

`default_nettype wire

// ===== rtl/led_rainbow_colour_cycler_top.sv =====
`default_nettype none

// Rainbow colour cycler for one LED. Each request transaction is one millisecond
// tick (req_tdata bit 0 requests a restart to black at palette index 1). A tick
// that only counts down the step wait, or that advances the palette index, is
// taken while the block stays idle and gives no response. A tick that moves the
// colour gives one response transaction with red, green, blue and white PWM
// duties, computed by the shared bit-serial multiply/divide unit, which handles
// one bit per cycle and passes over the three channels in turn (8 + 15 + 9 + 25
// steps plus the load and store states per channel). The response sits in an
// output register, so the next tick is taken while it waits. Configuration
// writes are taken at any time through csr_we.
module led_rainbow_colour_cycler_top (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,   // [0] restart, [7:1] zero fill
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [63:0]      rsp_tdata,   // [15:0] duty_red, [31:16] duty_green,
                                         // [47:32] duty_blue, [63:48] duty_white
   input  wire logic        csr_we,
   input  wire logic [2:0]  csr_addr,
   input  wire logic [15:0] csr_wdata
);
   import lrcc_pkg::*;

   // Configuration registers.
   logic [15:0] step_delay_ff;
   logic [6:0]  brightness_ff;
   logic        invert_duty_ff;
   logic [15:0] pwm_max_ff;
   logic        has_white_ff;

   // Sequence state.
   lrcc_state_type     state_ff, state_in;
   logic [15:0]        wait_ff, wait_in;
   rgb_type            colour_ff, colour_in;
   logic [2:0]         index_ff, index_in;
   logic [1:0]         ch_ff, ch_in;
   logic [4:0]         cnt_ff, cnt_in;

   // Serial datapath.
   logic [ACC_W-1:0]   acc_ff, acc_in;
   logic [ACC_W-1:0]   dq_ff, dq_in;
   logic [REM_W-1:0]   rem_ff, rem_in;
   logic [2:0][15:0]   duty_ff, duty_in;

   // Response register.
   logic               rsp_valid_ff, rsp_valid_in;
   logic [63:0]        rsp_data_ff, rsp_data_in;

   // Helpers.
   logic               req_fire;
   rgb_type            col_start;
   logic [2:0]         idx_start;
   rgb_type            tgt;
   rgb_type            col_moved;
   logic [2:0]         idx_next;
   logic [ACC_W-1:0]   mul_addend;
   logic [ACC_W-1:0]   mul_sum;
   logic [8:0]         divisor;
   logic [REM_W-1:0]   rem_shift;
   logic               rem_ge;
   logic [REM_W-1:0]   div_rem;
   logic [ACC_W-1:0]   div_dq;
   logic [15:0]        duty_sat;
   logic [15:0]        duty_final;
   logic [15:0]        duty_white;

   assign req_tready = (state_ff == ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // Tick decode: restart first, then target and one-step colour move.
   always_comb begin
      col_start = req_tdata[0] ? '{8'd0, 8'd0, 8'd0} : colour_ff;
      idx_start = req_tdata[0] ? 3'd1 : index_ff;
      tgt       = palette_target(idx_start);
      for (int k = 0; k < 3; k++) begin
         if (col_start[k] < tgt[k]) begin
            col_moved[k] = col_start[k] + 8'd1;
         end else if (col_start[k] > tgt[k]) begin
            col_moved[k] = col_start[k] - 8'd1;
         end else begin
            col_moved[k] = col_start[k];
         end
      end
      if ({1'b0, idx_start} >= PALETTE_SIZE) begin
         idx_next = 3'd1;
      end else begin
         idx_next = idx_start + 3'd1;
      end
   end

   // One shift-add multiply step and one restoring divide step per cycle.
   always_comb begin
      mul_addend = (state_ff == ST_MUL1) ? {{(ACC_W-7){1'b0}}, brightness_ff}
                                         : {{(ACC_W-16){1'b0}}, pwm_max_ff};
      mul_sum    = {acc_ff[ACC_W-2:0], 1'b0} + (dq_ff[ACC_W-1] ? mul_addend : '0);
      divisor    = (state_ff == ST_DIV1) ? DIV_PCT : DIV_FULL;
      rem_shift  = {rem_ff[REM_W-2:0], dq_ff[ACC_W-1]};
      rem_ge     = (rem_shift >= divisor);
      div_rem    = rem_ge ? (rem_shift - divisor) : rem_shift;
      div_dq     = {dq_ff[ACC_W-2:0], rem_ge};
   end

   // Saturate the quotient to full scale, then invert for a common anode.
   always_comb begin
      duty_sat   = (dq_ff > {{(ACC_W-16){1'b0}}, pwm_max_ff}) ? pwm_max_ff : dq_ff[15:0];
      duty_final = invert_duty_ff ? (pwm_max_ff - duty_sat) : duty_sat;
      duty_white = (has_white_ff && invert_duty_ff) ? pwm_max_ff : 16'd0;
   end

   // Next state and datapath control.
   always_comb begin
      state_in     = state_ff;
      wait_in      = wait_ff;
      colour_in    = colour_ff;
      index_in     = index_ff;
      ch_in        = ch_ff;
      cnt_in       = cnt_ff;
      acc_in       = acc_ff;
      dq_in        = dq_ff;
      rem_in       = rem_ff;
      duty_in      = duty_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               colour_in = col_start;
               index_in  = idx_start;
               if (wait_ff != 16'd0) begin
                  wait_in = wait_ff - 16'd1;
               end else begin
                  wait_in = step_delay_ff;
                  if (col_start == tgt) begin
                     index_in = idx_next;
                  end else begin
                     colour_in = col_moved;
                     ch_in     = 2'd0;
                     state_in  = ST_LOAD;
                  end
               end
            end
         end
         ST_LOAD: begin
            dq_in    = {colour_ff[ch_ff], {(ACC_W-8){1'b0}}};
            acc_in   = '0;
            cnt_in   = MUL1_LAST;
            state_in = ST_MUL1;
         end
         ST_MUL1: begin
            acc_in = mul_sum;
            dq_in  = {dq_ff[ACC_W-2:0], 1'b0};
            cnt_in = cnt_ff - 5'd1;
            if (cnt_ff == 5'd0) begin
               dq_in    = {mul_sum[14:0], {(ACC_W-15){1'b0}}};
               rem_in   = '0;
               cnt_in   = DIV1_LAST;
               state_in = ST_DIV1;
            end
         end
         ST_DIV1: begin
            rem_in = div_rem;
            dq_in  = div_dq;
            cnt_in = cnt_ff - 5'd1;
            if (cnt_ff == 5'd0) begin
               dq_in    = {div_dq[8:0], {(ACC_W-9){1'b0}}};
               acc_in   = '0;
               cnt_in   = MUL2_LAST;
               state_in = ST_MUL2;
            end
         end
         ST_MUL2: begin
            acc_in = mul_sum;
            dq_in  = {dq_ff[ACC_W-2:0], 1'b0};
            cnt_in = cnt_ff - 5'd1;
            if (cnt_ff == 5'd0) begin
               dq_in    = mul_sum;
               rem_in   = '0;
               cnt_in   = DIV2_LAST;
               state_in = ST_DIV2;
            end
         end
         ST_DIV2: begin
            rem_in = div_rem;
            dq_in  = div_dq;
            cnt_in = cnt_ff - 5'd1;
            if (cnt_ff == 5'd0) begin
               state_in = ST_STORE;
            end
         end
         ST_STORE: begin
            duty_in[ch_ff] = duty_final;
            if (ch_ff == 2'd2) begin
               state_in = ST_OUT;
            end else begin
               ch_in    = ch_ff + 2'd1;
               state_in = ST_LOAD;
            end
         end
         ST_OUT: begin
            // Hand over once the response register is free.
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {duty_white, duty_ff[2], duty_ff[1], duty_ff[0]};
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Control and sequence registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         wait_ff      <= 16'd0;
         colour_ff    <= '{8'd0, 8'd0, 8'd0};
         index_ff     <= 3'd1;
         ch_ff        <= 2'd0;
         cnt_ff       <= 5'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         wait_ff      <= wait_in;
         colour_ff    <= colour_in;
         index_ff     <= index_in;
         ch_ff        <= ch_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Datapath and response payload.
   always_ff @(posedge clock) begin
      acc_ff      <= acc_in;
      dq_ff       <= dq_in;
      rem_ff      <= rem_in;
      duty_ff     <= duty_in;
      rsp_data_ff <= rsp_data_in;
   end

   // Configuration writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         step_delay_ff  <= 16'd10;
         brightness_ff  <= 7'd100;
         invert_duty_ff <= 1'b0;
         pwm_max_ff     <= 16'd255;
         has_white_ff   <= 1'b0;
      end else if (csr_we) begin
         case (csr_addr)
            REG_STEP_DELAY:  step_delay_ff  <= csr_wdata;
            REG_BRIGHTNESS:  brightness_ff  <= csr_wdata[6:0];
            REG_INVERT_DUTY: invert_duty_ff <= csr_wdata[0];
            REG_PWM_MAX:     pwm_max_ff     <= csr_wdata;
            REG_HAS_WHITE:   has_white_ff   <= csr_wdata[0];
            default: begin
            end
         endcase
      end
   end

endmodule

`default_nettype wire
